>>> hw/rtl/sve_pkg.sv
// Shared types and constants for the smoothed velocity estimator.
// No dependencies; every other RTL file but sve_checker refers to it by scoped names.
`default_nettype none
package sve_pkg;

   localparam int MaxWindow    = 32;
   localparam int MaxInterval  = 32;
   localparam int HistDepth    = MaxInterval + 1;
   localparam int WinAw        = $clog2(MaxWindow);
   localparam int HistAw       = $clog2(HistDepth);
   localparam int LenW         = 6;
   localparam int RateW        = 8;
   localparam int PosW         = 32;
   localparam int SumW         = 37;
   localparam int DivW         = 41;
   localparam int CountW       = 7;
   localparam int CounterMax   = 127;

   localparam logic [1:0] CsrWindow   = 2'd0;
   localparam logic [1:0] CsrInterval = 2'd1;
   localparam logic [1:0] CsrRate     = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_D1_GO,
      ST_D1_WAIT,
      ST_HIST,
      ST_PREV,
      ST_D2_GO,
      ST_D2_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              win_we;
      logic [WinAw-1:0]  win_waddr;
      logic              win_re;
      logic [WinAw-1:0]  win_raddr;
      logic              s_clear;
      logic              first_clear;
      logic              div_start;
      logic              div_sel_prod;
      logic              s_load;
      logic              hist_we;
      logic [HistAw-1:0] hist_waddr;
      logic [HistAw-1:0] hist_raddr;
      logic              first_load;
      logic              prev_hist;
      logic              prod_load;
      logic              vel_load;
      logic [RateW-1:0]  rate;
      logic [LenW-1:0]   divisor;
   } lane_ctrl_type;

   function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v,
                                                 input logic [LenW-1:0] hi);
      logic [LenW-1:0] r;
      r = v;
      if (v == '0) r = LenW'(1);
      else if (v > hi) r = hi;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sve_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Uses sve_pkg for widths.
`default_nettype none
module sve_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [sve_pkg::DivW-1:0]   dividend,
   input  wire logic        [sve_pkg::LenW-1:0]   divisor,
   output logic                                   done,
   output logic signed      [sve_pkg::DivW-1:0]   quotient
);
   localparam int CntW = $clog2(sve_pkg::DivW + 1);

   logic                         busy_ff;
   logic                         done_ff;
   logic [CntW-1:0]              cnt_ff;
   logic                         neg_ff;
   logic [sve_pkg::LenW:0]       rem_ff;
   logic [sve_pkg::DivW-1:0]     quo_ff;
   logic [sve_pkg::LenW-1:0]     den_ff;
   logic [sve_pkg::LenW+1:0]     rem_sh;
   logic                         fits;

   assign rem_sh = {rem_ff, quo_ff[sve_pkg::DivW-1]};
   assign fits   = rem_sh >= {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(sve_pkg::DivW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[sve_pkg::DivW-1];
         quo_ff <= dividend[sve_pkg::DivW-1] ? -dividend : dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? (sve_pkg::LenW+1)'(rem_sh - {2'b00, den_ff})
                        : (sve_pkg::LenW+1)'(rem_sh);
         quo_ff <= {quo_ff[sve_pkg::DivW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule
`default_nettype wire

>>> hw/rtl/sve_lane.sv
// One axis lane: window store, running sum, smoothed history and velocity math.
// Uses sve_pkg and sve_div.
`default_nettype none
module sve_lane (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire sve_pkg::lane_ctrl_type         ctrl,
   input  wire logic signed [sve_pkg::PosW-1:0] pos,
   output logic signed [sve_pkg::PosW-1:0]     vel,
   output logic                                div_done
);
   logic signed [sve_pkg::PosW-1:0] win_mem [sve_pkg::MaxWindow];
   logic signed [sve_pkg::PosW-1:0] hist_mem [sve_pkg::HistDepth];
   logic signed [sve_pkg::PosW-1:0] win_rd_ff;
   logic signed [sve_pkg::PosW-1:0] hist_rd_ff;
   logic                            rd_valid_ff;
   logic signed [sve_pkg::SumW-1:0] acc_ff;
   logic signed [sve_pkg::PosW-1:0] s_ff;
   logic signed [sve_pkg::PosW-1:0] first_ff;
   logic signed [sve_pkg::DivW-1:0] prod_ff;
   logic signed [sve_pkg::PosW-1:0] vel_ff;
   logic signed [sve_pkg::PosW-1:0] prev;
   logic signed [sve_pkg::PosW:0]   diff;
   logic signed [sve_pkg::PosW+sve_pkg::RateW+1:0] prod_full;
   logic signed [sve_pkg::DivW-1:0] div_a;
   logic signed [sve_pkg::DivW-1:0] quo;
   logic                            done;

   always_ff @(posedge clock) begin
      if (ctrl.win_we) win_mem[ctrl.win_waddr] <= pos;
      if (ctrl.win_re) win_rd_ff <= win_mem[ctrl.win_raddr];
      if (ctrl.hist_we) hist_mem[ctrl.hist_waddr] <= s_ff;
      hist_rd_ff <= hist_mem[ctrl.hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else       rd_valid_ff <= ctrl.win_re;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
      end else if (ctrl.first_clear) begin
         first_ff <= '0;
      end else if (ctrl.first_load) begin
         first_ff <= s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s_clear) begin
         acc_ff <= '0;
         s_ff   <= '0;
      end else begin
         if (rd_valid_ff)
            acc_ff <= acc_ff + sve_pkg::SumW'(win_rd_ff);
         if (ctrl.s_load && done)
            s_ff <= quo[sve_pkg::PosW-1:0];
      end
      if (ctrl.prod_load) prod_ff <= prod_full[sve_pkg::DivW-1:0];
      if (ctrl.vel_load && done) begin
         if (quo > sve_pkg::DivW'(32'sh7FFF_FFFF))
            vel_ff <= 32'sh7FFF_FFFF;
         else if (quo < -sve_pkg::DivW'(64'sh8000_0000))
            vel_ff <= 32'sh8000_0000;
         else
            vel_ff <= quo[sve_pkg::PosW-1:0];
      end
   end

   assign prev      = ctrl.prev_hist ? hist_rd_ff : first_ff;
   assign diff      = (sve_pkg::PosW+1)'(s_ff) - (sve_pkg::PosW+1)'(prev);
   assign prod_full = diff * $signed({1'b0, ctrl.rate});
   assign div_a     = ctrl.div_sel_prod ? prod_ff : sve_pkg::DivW'(acc_ff);

   sve_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (div_a),
      .divisor  (ctrl.divisor),
      .done     (done),
      .quotient (quo)
   );

   assign vel      = vel_ff;
   assign div_done = done;
endmodule
`default_nettype wire

>>> hw/rtl/smoothed_velocity_estimator_unit.sv
// Top level: configuration registers, sequencer and result stage over three axis lanes.
// Uses sve_pkg and sve_lane.
//
//   channel | dir | tdata (low bit up)        | side
//   req     | in  | pos_x, pos_y, pos_z       | tuser start_trajectory
//   rsp     | out | vel_x, vel_y, vel_z       | tlast last_of_run
//   csr     | in  | index 0 window, 1 interval, 2 rate
//
// One frame at a time: the window sum (one read per cycle from the window memory),
// a divide on the bit-serial divider (twice when a velocity is due), bookkeeping,
// then the result words, one per cycle while rsp_tready is high.
// Reset is synchronous and clears control state; stores need no clearing.
// While results wait on rsp_tready the sequencer holds and req_tready stays low.
`default_nettype none
module smoothed_velocity_estimator_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,   // pos_x, pos_y, pos_z
   input  wire logic         req_tuser,   // start_trajectory
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [95:0]       rsp_tdata,   // vel_x, vel_y, vel_z
   output logic              rsp_tlast,   // last_of_run
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [7:0]   csr_wdata
);
   localparam int LW = sve_pkg::LenW;
   localparam int CW = sve_pkg::CountW;

   sve_pkg::state_type        state_ff, state_in;
   sve_pkg::lane_ctrl_type    ctrl;
   logic [LW-1:0]             window_ff, interval_ff;
   logic [sve_pkg::RateW-1:0] rate_ff;
   logic [CW-1:0]             counter_ff, t_ff, t_in;
   logic [sve_pkg::WinAw-1:0] win_ptr_ff;
   logic [sve_pkg::HistAw-1:0] hist_ptr_ff;
   logic [LW-1:0]             idx_ff, rem_ff;
   logic [LW-1:0]             n, k, m;
   logic [CW:0]               t_ext, kn_sum;
   logic [CW-1:0]             hist_rsum;
   logic [2:0]                done_v;
   logic [sve_pkg::PosW-1:0]  vel_v [3];
   logic                      accept, rsp_fire, div_done, finish;

   assign n      = sve_pkg::clamp_len(window_ff, LW'(sve_pkg::MaxWindow));
   assign k      = sve_pkg::clamp_len(interval_ff, LW'(sve_pkg::MaxInterval));
   assign m      = (n > k) ? n : k;
   assign accept = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign t_in   = req_tuser ? '0 : counter_ff;
   assign t_ext  = {1'b0, t_ff};
   assign kn_sum = (CW+1)'(k) + (CW+1)'(n);
   assign hist_rsum = CW'(hist_ptr_ff) + CW'(sve_pkg::HistDepth) - CW'(k);
   assign div_done  = done_v[0];
   assign finish = (state_ff == sve_pkg::ST_HIST && t_ff < CW'(m))
                || (state_ff == sve_pkg::ST_EMIT && rsp_fire && rem_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= LW'(4);
         interval_ff <= LW'(1);
         rate_ff     <= 8'd25;
      end else if (csr_we) begin
         case (csr_index)
            sve_pkg::CsrWindow:   window_ff   <= csr_wdata[LW-1:0];
            sve_pkg::CsrInterval: interval_ff <= csr_wdata[LW-1:0];
            sve_pkg::CsrRate:     rate_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sve_pkg::ST_IDLE:
            if (accept) state_in = (t_in >= CW'(n)) ? sve_pkg::ST_SUM : sve_pkg::ST_HIST;
         sve_pkg::ST_SUM:    if (idx_ff == n) state_in = sve_pkg::ST_D1_GO;
         sve_pkg::ST_D1_GO:  state_in = sve_pkg::ST_D1_WAIT;
         sve_pkg::ST_D1_WAIT: if (div_done) state_in = sve_pkg::ST_HIST;
         sve_pkg::ST_HIST:
            state_in = (t_ff >= CW'(m)) ? sve_pkg::ST_PREV : sve_pkg::ST_IDLE;
         sve_pkg::ST_PREV:   state_in = sve_pkg::ST_D2_GO;
         sve_pkg::ST_D2_GO:  state_in = sve_pkg::ST_D2_WAIT;
         sve_pkg::ST_D2_WAIT: if (div_done) state_in = sve_pkg::ST_EMIT;
         sve_pkg::ST_EMIT:   if (rsp_fire && rem_ff == '0) state_in = sve_pkg::ST_IDLE;
         default:            state_in = sve_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.rate       = rate_ff;
      ctrl.win_waddr  = win_ptr_ff;
      ctrl.win_raddr  = win_ptr_ff - idx_ff[sve_pkg::WinAw-1:0];
      ctrl.hist_waddr = hist_ptr_ff;
      ctrl.hist_raddr = (hist_rsum >= CW'(sve_pkg::HistDepth))
                      ? sve_pkg::HistAw'(hist_rsum - CW'(sve_pkg::HistDepth))
                      : sve_pkg::HistAw'(hist_rsum);
      ctrl.divisor    = n;
      ctrl.prev_hist  = t_ext >= kn_sum;
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      case (state_ff)
         sve_pkg::ST_IDLE: begin
            req_tready       = 1'b1;
            ctrl.win_we      = accept;
            ctrl.s_clear     = accept;
            ctrl.first_clear = accept && t_in == '0;
         end
         sve_pkg::ST_SUM:     ctrl.win_re = idx_ff < n;
         sve_pkg::ST_D1_GO:   ctrl.div_start = 1'b1;
         sve_pkg::ST_D1_WAIT: ctrl.s_load = 1'b1;
         sve_pkg::ST_HIST: begin
            ctrl.hist_we    = 1'b1;
            ctrl.first_load = t_ff == CW'(n);
         end
         sve_pkg::ST_PREV:    ctrl.prod_load = 1'b1;
         sve_pkg::ST_D2_GO: begin
            ctrl.div_start    = 1'b1;
            ctrl.div_sel_prod = 1'b1;
            ctrl.divisor      = k;
         end
         sve_pkg::ST_D2_WAIT: begin
            ctrl.div_sel_prod = 1'b1;
            ctrl.divisor      = k;
            ctrl.vel_load     = 1'b1;
         end
         sve_pkg::ST_EMIT:    rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sve_pkg::ST_IDLE;
         counter_ff  <= '0;
         t_ff        <= '0;
         win_ptr_ff  <= '0;
         hist_ptr_ff <= '0;
         idx_ff      <= '0;
         rem_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            t_ff       <= t_in;
            counter_ff <= (t_in < CW'(sve_pkg::CounterMax)) ? t_in + CW'(1) : t_in;
            idx_ff     <= '0;
         end else if (state_ff == sve_pkg::ST_SUM) begin
            idx_ff <= idx_ff + LW'(1);
         end
         // one copy per frame, m+1 copies on the first velocity frame
         if (state_ff == sve_pkg::ST_PREV)
            rem_ff <= (t_ff == CW'(m)) ? m : '0;
         else if (state_ff == sve_pkg::ST_EMIT && rsp_fire)
            rem_ff <= rem_ff - LW'(1);
         if (finish) begin
            win_ptr_ff  <= win_ptr_ff + sve_pkg::WinAw'(1);
            hist_ptr_ff <= (hist_ptr_ff == sve_pkg::HistAw'(sve_pkg::HistDepth - 1))
                         ? '0 : hist_ptr_ff + sve_pkg::HistAw'(1);
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      sve_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .pos      (req_tdata[g*32 +: 32]),
         .vel      (vel_v[g]),
         .div_done (done_v[g])
      );
   end

   assign rsp_tdata = {vel_v[2], vel_v[1], vel_v[0]};
   assign rsp_tlast = rem_ff == '0;
endmodule
`default_nettype wire

>>> hw/rtl/sve_checker.sv
// Port-level checks for smoothed_velocity_estimator_unit, bound to the top level.
// No package dependency.
`default_nettype none
module sve_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while results pending");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("run ended without last word");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");
endmodule

bind smoothed_velocity_estimator_unit sve_checker u_sve_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

>>> tb/sve_velocity_checker.sv
`timescale 1ns / 100ps
// Checker for the smoothed velocity estimator: watches csr, req and rsp, predicts velocity words.
// Depends on sve_pkg for the register indexes.
module sve_velocity_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,    // pos_x, pos_y, pos_z
   input  logic        req_tuser,    // start_trajectory
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,    // vel_x, vel_y, vel_z
   input  logic        rsp_tlast,    // last_of_run
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic [31:0] vz;
      logic [31:0] vy;
      logic [31:0] vx;
      logic        last;
   } velocity_word_type;

   velocity_word_type velocity_queue[$];

   logic [5:0] win_len;
   logic [5:0] interval_len;
   logic [7:0] rate;
   logic signed [31:0] win_store[3][32];
   logic signed [31:0] smooth_hist[3][33];
   logic signed [31:0] first_smooth[3];
   int unsigned frame_t;
   int unsigned win_ptr;
   int unsigned hist_ptr;
   int errors;

   function automatic int unsigned clamp_frames(input logic [5:0] v);
      if (v == 0) return 1;
      if (v > 32) return 32;
      return v;
   endfunction

   task automatic predict_frame(input logic start, input logic [95:0] pos);
      int unsigned n, k, m, t, cnt;
      logic signed [31:0] s[3];
      logic signed [31:0] v[3];
      logic signed [31:0] prev;
      longint acc, q;
      velocity_word_type w;
      n = clamp_frames(win_len);
      k = clamp_frames(interval_len);
      m = (n > k) ? n : k;
      if (start) frame_t = 0;
      t = frame_t;
      if (t == 0) for (int a = 0; a < 3; a++) first_smooth[a] = 0;
      for (int a = 0; a < 3; a++) win_store[a][win_ptr] = pos[32*a +: 32];
      for (int a = 0; a < 3; a++) begin
         s[a] = 0;
         if (t >= n) begin
            acc = 0;
            for (int i = 0; i < n; i++) acc += win_store[a][(win_ptr + 32 - i) % 32];
            s[a] = 32'(acc / longint'(n));
            if (t == n) first_smooth[a] = s[a];
         end
         smooth_hist[a][hist_ptr] = s[a];
      end
      if (t >= m) begin
         for (int a = 0; a < 3; a++) begin
            if (t >= k && t - k >= n) prev = smooth_hist[a][(hist_ptr + 33 - k) % 33];
            else prev = first_smooth[a];
            q = (longint'(s[a]) - longint'(prev)) * longint'(rate) / longint'(k);
            if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
            if (q < -64'sh8000_0000) q = -64'sh8000_0000;
            v[a] = 32'(q);
         end
         cnt = (t == m) ? m + 1 : 1;
         for (int i = 0; i < cnt; i++) begin
            w.vx = v[0];
            w.vy = v[1];
            w.vz = v[2];
            w.last = (i + 1 == cnt);
            velocity_queue.push_back(w);
         end
      end
      win_ptr = (win_ptr + 1) % 32;
      hist_ptr = (hist_ptr + 1) % 33;
      if (frame_t < 127) frame_t++;
   endtask

   task automatic check_word();
      velocity_word_type w;
      if (velocity_queue.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected word: vel %h %h %h last %b",
                     rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tlast);
         return;
      end
      w = velocity_queue.pop_front();
      if (rsp_tdata !== {w.vz, w.vy, w.vx} || rsp_tlast !== w.last) begin
         errors++;
         if (errors <= 10)
            $display("word mismatch: expected %h %h %h last %b, got %h %h %h last %b",
                     w.vx, w.vy, w.vz, w.last,
                     rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tlast);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         win_len = 4;
         interval_len = 1;
         rate = 25;
         frame_t = 0;
         win_ptr = 0;
         hist_ptr = 0;
         for (int a = 0; a < 3; a++) begin
            first_smooth[a] = 0;
            for (int i = 0; i < 32; i++) win_store[a][i] = 0;
            for (int i = 0; i < 33; i++) smooth_hist[a][i] = 0;
         end
         velocity_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               sve_pkg::CsrWindow:   win_len = csr_wdata[5:0];
               sve_pkg::CsrInterval: interval_len = csr_wdata[5:0];
               sve_pkg::CsrRate:     rate = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_word();
         if (req_tvalid && req_tready) predict_frame(req_tuser, req_tdata);
      end
      pending <= velocity_queue.size();
      fail_count <= errors;
   end

   initial begin
      errors = 0;
      pending = 0;
      fail_count = 0;
   end
endmodule

>>> tb/smoothed_velocity_estimator_unit_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for smoothed_velocity_estimator_unit; checking lives in sve_velocity_checker.
// Depends on sve_pkg, the RTL and tb/sve_velocity_checker.sv.
module smoothed_velocity_estimator_unit_tb;
   typedef enum int { POS_TRACK, POS_NOISE, POS_EXTREME, POS_MIXED } pos_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;    // pos_x, pos_y, pos_z
   logic        req_tuser;    // start_trajectory
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;    // vel_x, vel_y, vel_z
   logic        rsp_tlast;    // last_of_run
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;
   int          fail_count;
   int          pending;
   int          frames_sent;
   int          ready_hold;
   bit          steady;
   logic [31:0] track_pos[3];

   smoothed_velocity_estimator_unit DUT (.*);

   sve_velocity_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("smoothed_velocity_estimator_unit: mismatch");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         rsp_tready <= 0;
         ready_hold <= ready_hold - 1;
      end else if (!steady && $urandom_range(0, 9) < 3) begin
         rsp_tready <= 0;
         ready_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
      end else begin
         rsp_tready <= 1;
      end
   end

   function automatic logic [31:0] extreme_value();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic logic [95:0] next_position(input pos_mode_type mode);
      logic [95:0] p;
      pos_mode_type m;
      int r;
      m = mode;
      if (mode == POS_MIXED) begin
         r = $urandom_range(0, 99);
         m = (r < 80) ? POS_TRACK : (r < 95) ? POS_NOISE : POS_EXTREME;
      end
      for (int a = 0; a < 3; a++) begin
         case (m)
            POS_TRACK: begin
               track_pos[a] = track_pos[a] + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
               p[32*a +: 32] = track_pos[a];
            end
            POS_NOISE:   p[32*a +: 32] = $urandom;
            default:     p[32*a +: 32] = extreme_value();
         endcase
      end
      return p;
   endfunction

   task automatic send_frame(input logic start, input logic [95:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= pos;
      req_tuser <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      frames_sent++;
   endtask

   task automatic run_frames(input int count, input pos_mode_type mode, input bit fresh);
      for (int i = 0; i < count; i++)
         send_frame((i == 0 && fresh) || $urandom_range(0, 99) < 2, next_position(mode));
      req_tvalid <= 0;
   endtask

   // Frames before max(N,K) give no word, so the block may still be busy after the queue drains.
   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] n, input logic [7:0] k, input logic [7:0] r);
      drain();
      write_reg(sve_pkg::CsrWindow, n);
      write_reg(sve_pkg::CsrInterval, k);
      write_reg(sve_pkg::CsrRate, r);
   endtask

   initial begin
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= '0;
      req_tuser <= 0;
      csr_we <= 0;
      csr_index <= sve_pkg::CsrWindow;
      csr_wdata <= '0;
      steady = 0;
      frames_sent = 0;
      for (int a = 0; a < 3; a++) track_pos[a] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset configuration; first frame counts as a trajectory start
      run_frames(20, POS_EXTREME, 0);
      set_config(1, 1, 240);
      run_frames(15, POS_EXTREME, 1);
      set_config(0, 0, 0);
      run_frames(8, POS_NOISE, 1);
      // out-of-range lengths saturate; index 3 is not a register
      set_config(63, 63, 255);
      write_reg(2'd3, 8'hFF);
      steady = 1;
      run_frames(40, POS_MIXED, 1);
      steady = 0;
      set_config(2, 32, 100);
      run_frames(40, POS_MIXED, 1);
      set_config(5, 3, 60);
      run_frames(20, POS_TRACK, 1);
      // change lengths in the middle of a trajectory
      set_config(9, 2, 60);
      run_frames(20, POS_TRACK, 0);
      // run past the frame counter ceiling
      set_config(3, 2, 8'($urandom_range(1, 255)));
      run_frames(140, POS_MIXED, 1);
      while (frames_sent < 370) begin
         set_config(8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
                    8'($urandom_range(0, 255)));
         steady = ($urandom_range(0, 3) == 0);
         run_frames($urandom_range(5, 40), POS_MIXED, $urandom_range(0, 9) != 0);
      end
      steady = 0;
      drain();
      @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("smoothed_velocity_estimator_unit: match");
      else
         $display("smoothed_velocity_estimator_unit: mismatch");
      $finish;
   end
endmodule
